// ----- hdl/krr_pkg.sv -----
// Shared types, codes and defaults for the keyword rule key router.
package krr_pkg;

  localparam int NUM_RULES_DEF     = 128;
  localparam int PATTERN_LEN_DEF   = 32;
  localparam int KEYS_PER_RULE_DEF = 4;
  localparam int NUM_KEYS_DEF      = 64;
  localparam int TEXT_LIMIT_DEF    = 1023;

  // Most keys one text can produce, and the depth of the result buffer.
  localparam int MAX_OUT   = 64;
  localparam int CMD_DEPTH = 4;
  localparam int RES_DEPTH = 4;

  typedef enum logic [2:0] {
    OP_TEXT = 3'd0,
    OP_END  = 3'd1,
    OP_TRIG = 3'd2,
    OP_KEY  = 3'd3,
    OP_TLEN = 3'd4,
    OP_KCNT = 3'd5
  } op_t;

  localparam logic [1:0] REG_KEY_LIMIT  = 2'd0;
  localparam logic [1:0] REG_RULE_COUNT = 2'd1;

  typedef struct packed {
    op_t        op;
    logic       ok;
    logic [7:0] data;
    logic [6:0] rule;
    logic [4:0] pos;
    logic [5:0] key;
    logic [4:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic [6:0] key_limit;
    logic [7:0] rule_count;
  } cfg_t;

  typedef struct packed {
    logic [5:0] key_number;
    logic       key_valid;
    logic       last;
    logic [6:0] total_keys;
  } res_t;

  typedef struct packed {
    logic       wr_byte;
    logic       wr_len;
    logic       step;
    logic       clear;
    logic [4:0] pos;
    logic [7:0] data;
    logic [4:0] len;
  } cell_ctl_t;

  // Fold ASCII upper case to lower case; everything else passes.
  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) r = c + 8'd32;
    return r;
  endfunction

endpackage

// ----- hdl/keyword_rule_key_router_core.sv -----
// Top level of the keyword rule key router: front end, command queue, engine, result queue.
//
//   channel   handshake                 payload
//   input     push / full               operation byte_value rule_index position key_id count
//   result    pop / empty               key_number key_valid last total_keys
//   config    cfg_valid / cfg_ready     cfg_index cfg_data (key_limit, rule_count)
//
// A text byte or a load operation is taken by the engine in its run state; every rule
// matcher updates at once on a text byte. End of text walks the rules, one unmatched
// rule per cycle, stepping through the key slots of each matched rule, then emits each
// key through the registered result buffer read port.
// Reset clears control state, matchers and the seen map at once; no sweep.
// The command queue keeps taking items while the engine walks, and the result
// queue holds finished results while pop is low.
module keyword_rule_key_router_core #(
  parameter int NUM_RULES     = krr_pkg::NUM_RULES_DEF,
  parameter int PATTERN_LEN   = krr_pkg::PATTERN_LEN_DEF,
  parameter int KEYS_PER_RULE = krr_pkg::KEYS_PER_RULE_DEF,
  parameter int NUM_KEYS      = krr_pkg::NUM_KEYS_DEF,
  parameter int TEXT_LIMIT    = krr_pkg::TEXT_LIMIT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [2:0] operation,
  input  logic [7:0] byte_value,
  input  logic [6:0] rule_index,
  input  logic [4:0] position,
  input  logic [5:0] key_id,
  input  logic [4:0] count,
  output logic       empty,
  input  logic       pop,
  output logic [5:0] key_number,
  output logic       key_valid,
  output logic       last,
  output logic [6:0] total_keys,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import krr_pkg::*;

  localparam int CMD_W  = $bits(cmd_t);
  localparam int RES_W  = $bits(res_t);
  localparam int RLVL_W = $clog2(RES_DEPTH + 1);

  cmd_t              front_cmd, head_cmd;
  logic              keep, cmd_full, cmd_empty, cmd_pop;
  logic [CMD_W-1:0]  head_bits;
  logic [$clog2(CMD_DEPTH+1)-1:0] cmd_level;
  cfg_t              cfg;
  res_t              res, out_res;
  logic              res_push, res_room, res_full;
  logic [RES_W-1:0]  out_bits;
  logic [RLVL_W-1:0] res_level;

  // Configuration is always taken; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_limit  <= 7'(MAX_OUT);
      cfg.rule_count <= 8'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KEY_LIMIT:  cfg.key_limit  <= cfg_data[6:0];
        REG_RULE_COUNT: cfg.rule_count <= cfg_data;
        default: ;
      endcase
    end
  end

  krr_front #(
    .NUM_RULES(NUM_RULES), .PATTERN_LEN(PATTERN_LEN),
    .KEYS_PER_RULE(KEYS_PER_RULE), .NUM_KEYS(NUM_KEYS)
  ) u_front (
    .operation (operation),
    .byte_value(byte_value),
    .rule_index(rule_index),
    .position  (position),
    .key_id    (key_id),
    .count     (count),
    .cmd       (front_cmd),
    .keep      (keep)
  );

  // Unused operation codes are transferred and dropped here.
  assign full = cmd_full;

  krr_fifo #(.WIDTH(CMD_W), .DEPTH(CMD_DEPTH)) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .push (push && keep),
    .din  (front_cmd),
    .full (cmd_full),
    .pop  (cmd_pop),
    .dout (head_bits),
    .empty(cmd_empty),
    .level(cmd_level)
  );

  assign head_cmd = cmd_t'(head_bits);

  krr_engine #(
    .NUM_RULES(NUM_RULES), .PATTERN_LEN(PATTERN_LEN),
    .KEYS_PER_RULE(KEYS_PER_RULE), .NUM_KEYS(NUM_KEYS), .TEXT_LIMIT(TEXT_LIMIT)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .cmd_avail(!cmd_empty && (cmd_level != '0)),
    .cmd      (head_cmd),
    .cmd_pop  (cmd_pop),
    .cfg      (cfg),
    .res_room (res_room),
    .res_push (res_push),
    .res      (res)
  );

  // Two free slots cover the one result that may already be in flight.
  assign res_room = !res_full && (res_level <= RLVL_W'(RES_DEPTH - 2));

  krr_fifo #(.WIDTH(RES_W), .DEPTH(RES_DEPTH)) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .din  (res),
    .full (res_full),
    .pop  (pop),
    .dout (out_bits),
    .empty(empty),
    .level(res_level)
  );

  assign out_res    = res_t'(out_bits);
  assign key_number = out_res.key_number;
  assign key_valid  = out_res.key_valid;
  assign last       = out_res.last;
  assign total_keys = out_res.total_keys;
endmodule

// ----- hdl/krr_fifo.sv -----
// Small first-in first-out queue used between the parts of the router.
module krr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = krr_pkg::CMD_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [WIDTH-1:0]             din,
  output logic                         full,
  input  logic                         pop,
  output logic [WIDTH-1:0]             dout,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   level
);
  localparam int PTR_W = $clog2(DEPTH > 1 ? DEPTH : 2);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] cnt;
  logic             do_push, do_pop;

  assign full    = (cnt == CNT_W'(DEPTH));
  assign empty   = (cnt == '0);
  assign level   = cnt;
  assign dout    = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      cnt <= cnt + 1'b1;
      else if (do_pop && !do_push) cnt <= cnt - 1'b1;
    end
  end
endmodule

// ----- hdl/krr_front.sv -----
// Front end: classify an input item, check ranges, fold and saturate fields.
module krr_front #(
  parameter int NUM_RULES     = krr_pkg::NUM_RULES_DEF,
  parameter int PATTERN_LEN   = krr_pkg::PATTERN_LEN_DEF,
  parameter int KEYS_PER_RULE = krr_pkg::KEYS_PER_RULE_DEF,
  parameter int NUM_KEYS      = krr_pkg::NUM_KEYS_DEF
) (
  input  logic [2:0]     operation,
  input  logic [7:0]     byte_value,
  input  logic [6:0]     rule_index,
  input  logic [4:0]     position,
  input  logic [5:0]     key_id,
  input  logic [4:0]     count,
  output krr_pkg::cmd_t  cmd,
  output logic           keep
);
  import krr_pkg::*;

  logic [5:0] kmod [64];
  logic       rule_ok;

  for (genvar i = 0; i < 64; i++) begin : g_kmod
    assign kmod[i] = 6'(i % NUM_KEYS);
  end

  assign rule_ok = int'(rule_index) < NUM_RULES;

  always_comb begin
    cmd      = '0;
    cmd.op   = op_t'(operation);
    cmd.data = fold(byte_value);
    cmd.rule = rule_index;
    cmd.pos  = position;
    cmd.key  = kmod[key_id];
    cmd.cnt  = count;
    keep     = 1'b1;
    unique case (operation)
      OP_TEXT, OP_END: cmd.ok = 1'b1;
      OP_TRIG: cmd.ok = rule_ok && (int'(position) < PATTERN_LEN);
      OP_KEY:  cmd.ok = rule_ok && (int'(position) < KEYS_PER_RULE);
      OP_TLEN: begin
        cmd.ok = rule_ok;
        if (int'(count) > PATTERN_LEN - 1) cmd.cnt = 5'(PATTERN_LEN - 1);
      end
      OP_KCNT: begin
        cmd.ok = rule_ok;
        if (int'(count) > KEYS_PER_RULE) cmd.cnt = 5'(KEYS_PER_RULE);
      end
      default: keep = 1'b0;
    endcase
  end
endmodule

// ----- hdl/krr_rule_cell.sv -----
// One rule's trigger pattern and its case-folded shift-and matcher.
module krr_rule_cell #(
  parameter int PATTERN_LEN = krr_pkg::PATTERN_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  krr_pkg::cell_ctl_t ctl,
  input  logic               sel,
  output logic               hit
);
  import krr_pkg::*;

  localparam int PW    = PATTERN_LEN - 1;
  localparam int LEN_W = $clog2(PATTERN_LEN);

  logic [7:0]       pat [PW];
  logic [LEN_W-1:0] len;
  logic [PW-1:0]    prog, valid, eq, p, tail;
  logic             matched;

  always_ff @(posedge clk) begin
    if (ctl.wr_byte && sel) begin
      for (int i = 0; i < PW; i++) begin
        if (int'(ctl.pos) == i) pat[i] <= ctl.data;
      end
    end
    if (ctl.wr_len && sel) len <= LEN_W'(ctl.len);
  end

  // Effective length stops at the first zero byte.
  always_comb begin
    valid[0] = (int'(len) > 0) && (pat[0] != 8'd0);
    eq[0]    = (pat[0] == ctl.data);
    for (int i = 1; i < PW; i++) begin
      valid[i] = valid[i-1] && (int'(len) > i) && (pat[i] != 8'd0);
      eq[i]    = (pat[i] == ctl.data);
    end
    tail = valid & ~(valid >> 1);
    p    = ((prog << 1) | PW'(1)) & eq & valid;
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      prog    <= '0;
      matched <= 1'b0;
    end else if (ctl.step && valid[0]) begin
      prog <= p;
      if (|(p & tail)) matched <= 1'b1;
    end
  end

  assign hit = matched || !valid[0];
endmodule

// ----- hdl/krr_engine.sv -----
// Back end: rule store, matcher array, end-of-text walk and result emission.
module krr_engine #(
  parameter int NUM_RULES     = krr_pkg::NUM_RULES_DEF,
  parameter int PATTERN_LEN   = krr_pkg::PATTERN_LEN_DEF,
  parameter int KEYS_PER_RULE = krr_pkg::KEYS_PER_RULE_DEF,
  parameter int NUM_KEYS      = krr_pkg::NUM_KEYS_DEF,
  parameter int TEXT_LIMIT    = krr_pkg::TEXT_LIMIT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_avail,
  input  krr_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  krr_pkg::cfg_t cfg,
  input  logic          res_room,
  output logic          res_push,
  output krr_pkg::res_t res
);
  import krr_pkg::*;

  localparam int RULE_W = $clog2(NUM_RULES > 1 ? NUM_RULES : 2);
  localparam int RCNT_W = $clog2(NUM_RULES + 1);
  localparam int SLOT_W = $clog2(KEYS_PER_RULE > 1 ? KEYS_PER_RULE : 2);
  localparam int KCNT_W = $clog2(KEYS_PER_RULE + 1);
  localparam int KEY_W  = $clog2(NUM_KEYS);
  localparam int POS_W  = $clog2(TEXT_LIMIT + 1);
  localparam int OUT_W  = $clog2(MAX_OUT);
  localparam int N_W    = $clog2(MAX_OUT + 1);

  typedef enum logic [3:0] {
    S_RUN  = 4'b0001,
    S_RULE = 4'b0010,
    S_KEY  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t                state, state_next;
  logic [RCNT_W-1:0]     r_idx, r_idx_next, rules, rules_next;
  logic [KCNT_W-1:0]     k_idx, k_idx_next;
  logic [N_W-1:0]        n, n_next, limit, limit_next, j, j_next;
  logic                  rd_pend, rd_pend_next;
  logic [POS_W-1:0]      text_pos, text_pos_next;
  logic [NUM_KEYS-1:0]   seen;
  logic                  seen_set;
  logic [6:0]            lim_a;

  logic [5:0]            key_mem [NUM_RULES << SLOT_W];
  logic [5:0]            key_q;
  logic [RULE_W+SLOT_W-1:0] key_wa, key_ra;
  logic                  key_we;
  logic [KCNT_W-1:0]     cnt_mem [NUM_RULES];
  logic [KCNT_W-1:0]     cnt_q;
  logic                  cnt_we;
  logic [5:0]            obuf [MAX_OUT];
  logic [5:0]            obuf_q;
  logic                  obuf_we;
  logic [SLOT_W-1:0]     slot_rd;

  cell_ctl_t             ctl;
  logic [NUM_RULES-1:0]  sel, hit;

  for (genvar gr = 0; gr < NUM_RULES; gr++) begin : g_cell
    assign sel[gr] = (int'(cmd.rule) == gr);
    krr_rule_cell #(.PATTERN_LEN(PATTERN_LEN)) u_cell (
      .clk (clk),
      .rst (rst),
      .ctl (ctl),
      .sel (sel[gr]),
      .hit (hit[gr])
    );
  end

  assign key_wa  = {RULE_W'(cmd.rule), SLOT_W'(cmd.pos)};
  assign slot_rd = (state == S_KEY) ? SLOT_W'(k_idx + 1'b1) : '0;
  assign key_ra  = {r_idx[RULE_W-1:0], slot_rd};

  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_wa] <= cmd.key;
    key_q <= key_mem[key_ra];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[RULE_W'(cmd.rule)] <= KCNT_W'(cmd.cnt);
    cnt_q <= cnt_mem[r_idx[RULE_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (obuf_we) obuf[n[OUT_W-1:0]] <= key_q;
    obuf_q <= obuf[j[OUT_W-1:0]];
  end

  always_comb begin
    state_next    = state;
    r_idx_next    = r_idx;
    k_idx_next    = k_idx;
    n_next        = n;
    limit_next    = limit;
    rules_next    = rules;
    j_next        = j;
    rd_pend_next  = rd_pend;
    text_pos_next = text_pos;
    seen_set      = 1'b0;
    cmd_pop       = 1'b0;
    key_we        = 1'b0;
    cnt_we        = 1'b0;
    obuf_we       = 1'b0;
    res_push      = 1'b0;
    res           = '0;
    ctl           = '0;
    ctl.pos       = cmd.pos;
    ctl.data      = cmd.data;
    ctl.len       = cmd.cnt;
    lim_a = (cfg.key_limit > 7'(MAX_OUT)) ? 7'(MAX_OUT) : cfg.key_limit;

    unique case (state)
      S_RUN: begin
        if (cmd_avail) begin
          cmd_pop = 1'b1;
          unique case (cmd.op)
            OP_TEXT: begin
              if (text_pos < POS_W'(TEXT_LIMIT)) begin
                if (cmd.data == 8'd0) begin
                  text_pos_next = POS_W'(TEXT_LIMIT);
                end else begin
                  text_pos_next = text_pos + 1'b1;
                  ctl.step      = 1'b1;
                end
              end
            end
            OP_END: begin
              limit_next = (int'(lim_a) > NUM_KEYS) ? N_W'(NUM_KEYS) : N_W'(lim_a);
              rules_next = (int'(cfg.rule_count) > NUM_RULES) ? RCNT_W'(NUM_RULES)
                                                              : RCNT_W'(cfg.rule_count);
              r_idx_next = '0;
              n_next     = '0;
              state_next = S_RULE;
            end
            OP_TRIG: ctl.wr_byte = cmd.ok;
            OP_KEY:  key_we      = cmd.ok;
            OP_TLEN: ctl.wr_len  = cmd.ok;
            OP_KCNT: cnt_we      = cmd.ok;
            default: ;
          endcase
        end
      end
      S_RULE: begin
        if (r_idx >= rules) begin
          ctl.clear     = 1'b1;
          text_pos_next = '0;
          j_next        = '0;
          rd_pend_next  = 1'b0;
          state_next    = S_EMIT;
        end else if (!hit[r_idx[RULE_W-1:0]]) begin
          r_idx_next = r_idx + 1'b1;
        end else begin
          k_idx_next = '0;
          state_next = S_KEY;
        end
      end
      S_KEY: begin
        if (k_idx < cnt_q && n < limit) begin
          if (!seen[KEY_W'(key_q)]) begin
            seen_set = 1'b1;
            obuf_we  = 1'b1;
            n_next   = n + 1'b1;
          end
          k_idx_next = k_idx + 1'b1;
        end else begin
          r_idx_next = r_idx + 1'b1;
          state_next = S_RULE;
        end
      end
      S_EMIT: begin
        if (n == '0) begin
          if (res_room) begin
            res_push   = 1'b1;
            res.last   = 1'b1;
            state_next = S_RUN;
          end
        end else if (rd_pend) begin
          res_push       = 1'b1;
          res.key_number = obuf_q;
          res.key_valid  = 1'b1;
          res.last       = (j == n);
          res.total_keys = 7'(n);
          rd_pend_next   = 1'b0;
          if (j == n) state_next = S_RUN;
        end else if (res_room) begin
          rd_pend_next = 1'b1;
          j_next       = j + 1'b1;
        end
      end
      default: state_next = S_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_RUN;
      r_idx    <= '0;
      k_idx    <= '0;
      n        <= '0;
      limit    <= '0;
      rules    <= '0;
      j        <= '0;
      rd_pend  <= 1'b0;
      text_pos <= '0;
      seen     <= '0;
    end else begin
      state    <= state_next;
      r_idx    <= r_idx_next;
      k_idx    <= k_idx_next;
      n        <= n_next;
      limit    <= limit_next;
      rules    <= rules_next;
      j        <= j_next;
      rd_pend  <= rd_pend_next;
      text_pos <= text_pos_next;
      if (ctl.clear)     seen <= '0;
      else if (seen_set) seen[KEY_W'(key_q)] <= 1'b1;
    end
  end
endmodule

// ----- hdl/krr_checker.sv -----
// Port-level checks for the router, bound to the top level.
module krr_checker (
  input logic       clk,
  input logic       rst,
  input logic       push,
  input logic       full,
  input logic [2:0] operation,
  input logic [7:0] byte_value,
  input logic [6:0] rule_index,
  input logic [4:0] position,
  input logic [5:0] key_id,
  input logic [4:0] count,
  input logic       empty,
  input logic       pop,
  input logic [5:0] key_number,
  input logic       key_valid,
  input logic       last,
  input logic [6:0] total_keys,
  input logic       cfg_valid,
  input logic       cfg_ready,
  input logic [1:0] cfg_index,
  input logic [7:0] cfg_data
);
  a_nokey_form: assert property (@(posedge clk) disable iff (rst)
    (!empty && !key_valid) |-> (last && total_keys == 7'd0 && key_number == 6'd0))
    else $error("no-key result malformed");

  a_key_total: assert property (@(posedge clk) disable iff (rst)
    (!empty && key_valid) |-> (total_keys != 7'd0 && total_keys <= 7'd64))
    else $error("key result with bad total");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(key_number) && $stable(last)))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("results present after reset");
endmodule

bind keyword_rule_key_router_core krr_checker u_chk (.*);

// ----- tb/testbench.sv -----
// Testbench for keyword_rule_key_router_core: rule loads, text streams, predicted key output.
module testbench;
  import krr_pkg::*;

  localparam int RULES = NUM_RULES_DEF;
  localparam int PLEN  = PATTERN_LEN_DEF;
  localparam int KPR   = KEYS_PER_RULE_DEF;
  localparam int KEYS  = NUM_KEYS_DEF;
  localparam int TLIM  = TEXT_LIMIT_DEF;

  // Idle modes: none, sender idle, receiver stalls, both.
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [2:0] operation = '0;
  logic [7:0] byte_value = '0;
  logic [6:0] rule_index = '0;
  logic [4:0] position = '0;
  logic [5:0] key_id = '0;
  logic [4:0] count = '0;
  logic       empty;
  logic       pop = 1'b0;
  logic [5:0] key_number;
  logic       key_valid;
  logic       last;
  logic [6:0] total_keys;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  keyword_rule_key_router_core uut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .operation(operation), .byte_value(byte_value), .rule_index(rule_index),
    .position(position), .key_id(key_id), .count(count),
    .empty(empty), .pop(pop), .key_number(key_number), .key_valid(key_valid),
    .last(last), .total_keys(total_keys),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Mirror of the block state.
  logic [7:0]  trig_mem [RULES][PLEN];
  logic [4:0]  trig_len [RULES];
  logic [5:0]  slot_key [RULES][KPR];
  logic [2:0]  slot_cnt [RULES];
  logic [31:0] progress [RULES];
  logic        hit      [RULES];
  logic        emitted  [KEYS];
  int          text_pos;
  logic [6:0]  key_limit_reg;
  logic [7:0]  rule_count_reg;
  // Which store entries have been written, so nothing unwritten is ever read.
  logic        trig_written [RULES][PLEN];
  logic        slot_written [RULES][KPR];

  res_t key_queue[$];
  int   err_count = 0;
  int   idle_mode = IDLE_NONE;
  int   hold_left = 0;

  typedef struct {
    op_t        op;
    logic [7:0] b;
    logic [6:0] ri;
    logic [4:0] pos;
    logic [5:0] kid;
    logic [4:0] cnt;
    logic       typed;
    res_t       res;
  } stim_row_t;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    err_count++;
  endtask

  function automatic logic [7:0] lower_case(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
  endfunction

  function automatic int trigger_span(input int r);
    for (int i = 0; i < trig_len[r]; i++)
      if (trig_mem[r][i] == 8'h00) return i;
    return trig_len[r];
  endfunction

  function automatic void reset_text();
    for (int r = 0; r < RULES; r++) begin
      progress[r] = '0;
      hit[r] = 1'b0;
    end
    for (int k = 0; k < KEYS; k++) emitted[k] = 1'b0;
    text_pos = 0;
  endfunction

  function automatic void scan_byte(input logic [7:0] b);
    logic [7:0]  c;
    logic [31:0] eq, p;
    int          len;
    c = lower_case(b);
    if (text_pos >= TLIM) return;
    if (b == 8'h00) begin
      text_pos = TLIM;
      return;
    end
    text_pos++;
    for (int r = 0; r < RULES; r++) begin
      len = trigger_span(r);
      if (len == 0) continue;
      eq = '0;
      for (int i = 0; i < len; i++)
        if (lower_case(trig_mem[r][i]) == c) eq[i] = 1'b1;
      p = ((progress[r] << 1) | 32'd1) & eq;
      if (p[len-1]) hit[r] = 1'b1;
      progress[r] = p;
    end
  endfunction

  // Walk the rules at end of text and queue the keys they route to.
  function automatic void route_keys();
    logic [5:0] found [$];
    int         lim, rules;
    res_t       rs;
    lim   = (key_limit_reg > MAX_OUT) ? MAX_OUT : key_limit_reg;
    rules = (rule_count_reg > RULES) ? RULES : rule_count_reg;
    for (int r = 0; r < rules; r++) begin
      if (!hit[r] && trigger_span(r) != 0) continue;
      for (int k = 0; k < slot_cnt[r] && k < KPR && found.size() < lim; k++) begin
        if (emitted[slot_key[r][k]]) continue;
        emitted[slot_key[r][k]] = 1'b1;
        found.push_back(slot_key[r][k]);
      end
    end
    reset_text();
    if (found.size() == 0) begin
      rs = '{key_number: 6'd0, key_valid: 1'b0, last: 1'b1, total_keys: 7'd0};
      key_queue.push_back(rs);
    end else begin
      foreach (found[j]) begin
        rs.key_number = found[j];
        rs.key_valid  = 1'b1;
        rs.last       = (j == found.size() - 1);
        rs.total_keys = 7'(found.size());
        key_queue.push_back(rs);
      end
    end
  endfunction

  function automatic void apply_item(input logic [2:0] op, input logic [7:0] b,
                                     input logic [6:0] ri, input logic [4:0] pos,
                                     input logic [5:0] kid, input logic [4:0] cnt);
    case (op)
      OP_TEXT: scan_byte(b);
      OP_END:  route_keys();
      OP_TRIG: begin
        trig_mem[ri][pos] = b;
        trig_written[ri][pos] = 1'b1;
      end
      OP_KEY: if (pos < KPR) begin
        slot_key[ri][pos] = kid;
        slot_written[ri][pos] = 1'b1;
      end
      OP_TLEN: trig_len[ri] = 5'((cnt > PLEN - 1) ? PLEN - 1 : cnt);
      OP_KCNT: slot_cnt[ri] = 3'((cnt > KPR) ? KPR : cnt);
      default: ;
    endcase
  endfunction

  // Offer one item and hold it until the block takes it.
  task automatic offer_item(input logic [2:0] op, input logic [7:0] b, input logic [6:0] ri,
                            input logic [4:0] pos, input logic [5:0] kid,
                            input logic [4:0] cnt);
    while ((idle_mode == IDLE_SEND && $urandom_range(99) < 58) ||
           (idle_mode == IDLE_BOTH && $urandom_range(99) < 11)) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    operation <= op;
    byte_value <= b;
    rule_index <= ri;
    position <= pos;
    key_id <= kid;
    count <= cnt;
    @(posedge clk);
    while (full) @(posedge clk);
    apply_item(op, b, ri, pos, kid, cnt);
  endtask

  // Length and count writes first fill any slot they would expose.
  task automatic load_length(input int r, input logic [4:0] cnt);
    int n;
    n = (cnt > PLEN - 1) ? PLEN - 1 : cnt;
    for (int i = 0; i < n; i++)
      if (!trig_written[r][i]) offer_item(OP_TRIG, 8'($urandom), 7'(r), 5'(i), '0, '0);
    offer_item(OP_TLEN, 8'($urandom), 7'(r), 5'($urandom), 6'($urandom), cnt);
  endtask

  task automatic load_count(input int r, input logic [4:0] cnt);
    int n;
    n = (cnt > KPR) ? KPR : cnt;
    for (int i = 0; i < n; i++)
      if (!slot_written[r][i]) offer_item(OP_KEY, '0, 7'(r), 5'(i), 6'($urandom), '0);
    offer_item(OP_KCNT, 8'($urandom), 7'(r), 5'($urandom), 6'($urandom), cnt);
  endtask

  // Drop push and wait until every result is out and the engine has settled.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (key_queue.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_KEY_LIMIT) key_limit_reg = data[6:0];
    else if (idx == REG_RULE_COUNT) rule_count_reg = data;
    @(posedge clk);
  endtask

  function automatic logic [7:0] text_char();
    logic [7:0] pick [6] = '{8'h61, 8'h41, 8'h62, 8'h42, 8'h78, 8'h58};
    int d;
    d = $urandom_range(99);
    if (d < 70) return pick[$urandom_range(5)];
    if (d < 97) return 8'($urandom_range(255, 1));
    return 8'h00;
  endfunction

  // Load a rule with a trigger, usually short and mostly from the small alphabet, and random keys.
  task automatic load_rule(input int r);
    int n;
    n = ($urandom_range(9) == 0) ? 31 : $urandom_range(4);
    for (int i = 0; i < n; i++) offer_item(OP_TRIG, text_char(), 7'(r), 5'(i), '0, '0);
    load_length(r, ($urandom_range(9) == 0) ? 5'($urandom) : 5'(n));
    for (int k = 0; k < KPR; k++)
      if ($urandom_range(3) != 0) offer_item(OP_KEY, '0, 7'(r), 5'(k), 6'($urandom), '0);
    load_count(r, ($urandom_range(7) == 0) ? 5'($urandom) : 5'($urandom_range(KPR)));
  endtask

  // A text that usually carries some rule's trigger with random case.
  task automatic send_text();
    int r, n;
    logic [7:0] c;
    r = $urandom_range(7);
    repeat ($urandom_range(3)) offer_item(OP_TEXT, text_char(), '0, '0, '0, '0);
    if ($urandom_range(3) != 0) begin
      n = trigger_span(r);
      for (int i = 0; i < n; i++) begin
        c = trig_mem[r][i];
        if ($urandom_range(1) && c >= 8'h61 && c <= 8'h7a) c = c - 8'd32;
        offer_item(OP_TEXT, c, 7'($urandom), 5'($urandom), 6'($urandom), 5'($urandom));
      end
    end
    repeat ($urandom_range(3)) offer_item(OP_TEXT, text_char(), '0, '0, '0, '0);
    offer_item(OP_END, 8'($urandom), 7'($urandom), 5'($urandom), 6'($urandom),
               5'($urandom));
  endtask

  // Any operation with random fields; lengths and counts go through the safe path.
  task automatic send_noise();
    logic [2:0] op;
    op = 3'($urandom);
    if (op == OP_TLEN) load_length($urandom_range(RULES - 1), 5'($urandom));
    else if (op == OP_KCNT) load_count($urandom_range(RULES - 1), 5'($urandom));
    else offer_item(op, 8'($urandom), 7'($urandom), 5'($urandom), 6'($urandom),
                    5'($urandom));
  endtask

  // Receiver: check each transfer, then pick the next pop.
  always @(posedge clk) begin
    res_t want;
    if (!rst && pop && !empty) begin
      if (key_queue.size() == 0) begin
        report_mismatch($sformatf("result with none expected, key %0d", key_number));
      end else begin
        want = key_queue.pop_front();
        if (key_number !== want.key_number)
          report_mismatch($sformatf("key_number %0d, want %0d", key_number, want.key_number));
        if (key_valid !== want.key_valid)
          report_mismatch($sformatf("key_valid %0b, want %0b", key_valid, want.key_valid));
        if (last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", last, want.last));
        if (total_keys !== want.total_keys)
          report_mismatch($sformatf("total_keys %0d, want %0d", total_keys, want.total_keys));
      end
    end
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (idle_mode == IDLE_RECV) begin
      pop <= ($urandom_range(99) >= 58);
    end else if (idle_mode == IDLE_BOTH) begin
      pop <= ($urandom_range(99) >= 11);
    end else begin
      pop <= 1'b1;
    end
  end

  initial begin
    #50_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    stim_row_t  rows [$];
    logic [7:0] mk_pick [6] = '{8'd0, 8'd1, 8'd2, 8'd64, 8'd255, 8'd3};
    logic [7:0] rc_pick [6] = '{8'd0, 8'd1, 8'd8, 8'd128, 8'd255, 8'd5};
    int         base;

    for (int r = 0; r < RULES; r++) begin
      trig_len[r] = '0;
      slot_cnt[r] = '0;
      for (int i = 0; i < PLEN; i++) begin
        trig_mem[r][i] = '0;
        trig_written[r][i] = 1'b0;
      end
      for (int k = 0; k < KPR; k++) begin
        slot_key[r][k] = '0;
        slot_written[r][k] = 1'b0;
      end
    end
    reset_text();
    key_limit_reg = 7'd64;
    rule_count_reg = 8'd0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Each matcher reads its own trigger length, so give each rule an empty trigger and no keys.
    for (int r = 0; r < RULES; r++) begin
      offer_item(OP_TLEN, '0, 7'(r), '0, '0, '0);
      offer_item(OP_KCNT, '0, 7'(r), '0, '0, '0);
    end
    drain();

    // With no rules in use nothing can match.
    offer_item(OP_END, '0, '0, '0, '0, '0);
    key_queue.pop_back();
    key_queue.push_back('{6'd0, 1'b0, 1'b1, 7'd0});
    drain();
    write_reg(REG_RULE_COUNT, 8'd4);
    write_reg(REG_KEY_LIMIT, 8'd64);

    // Directed table: case folding, duplicate keys, slot and count caps,
    // empty trigger, zero inside a trigger, zero in the text, unused codes.
    rows = '{
      '{OP_TRIG, 8'h41, 7'd0, 5'd0, 6'd0, 5'd0, 1'b0, '0},
      '{OP_TRIG, 8'h62, 7'd0, 5'd1, 6'd0, 5'd0, 1'b0, '0},
      '{OP_TLEN, 8'h00, 7'd0, 5'd0, 6'd0, 5'd2, 1'b0, '0},
      '{OP_KEY,  8'h00, 7'd0, 5'd0, 6'd63, 5'd0, 1'b0, '0},
      '{OP_KEY,  8'h00, 7'd0, 5'd1, 6'd0, 5'd0, 1'b0, '0},
      '{OP_KEY,  8'h00, 7'd0, 5'd2, 6'd63, 5'd0, 1'b0, '0},
      '{OP_KEY,  8'h00, 7'd0, 5'd3, 6'd5, 5'd0, 1'b0, '0},
      '{OP_KEY,  8'h00, 7'd0, 5'd31, 6'd9, 5'd0, 1'b0, '0},
      '{OP_KCNT, 8'h00, 7'd0, 5'd0, 6'd0, 5'd31, 1'b0, '0},
      '{OP_KEY,  8'h00, 7'd1, 5'd0, 6'd7, 5'd0, 1'b0, '0},
      '{OP_KCNT, 8'h00, 7'd1, 5'd0, 6'd0, 5'd1, 1'b0, '0},
      '{OP_TRIG, 8'h78, 7'd2, 5'd0, 6'd0, 5'd0, 1'b0, '0},
      '{OP_TRIG, 8'h00, 7'd2, 5'd1, 6'd0, 5'd0, 1'b0, '0},
      '{OP_TLEN, 8'h00, 7'd2, 5'd0, 6'd0, 5'd2, 1'b0, '0},
      '{OP_KEY,  8'h00, 7'd2, 5'd0, 6'd42, 5'd0, 1'b0, '0},
      '{OP_KCNT, 8'h00, 7'd2, 5'd0, 6'd0, 5'd1, 1'b0, '0},
      '{OP_TEXT, 8'h61, 7'd0, 5'd0, 6'd0, 5'd0, 1'b0, '0},
      '{OP_TEXT, 8'h42, 7'd0, 5'd0, 6'd0, 5'd0, 1'b0, '0},
      '{OP_TEXT, 8'h00, 7'd0, 5'd0, 6'd0, 5'd0, 1'b0, '0},
      '{OP_TEXT, 8'h78, 7'd0, 5'd0, 6'd0, 5'd0, 1'b0, '0},
      '{op_t'(3'd6), 8'hff, 7'd127, 5'd31, 6'd63, 5'd31, 1'b0, '0},
      '{op_t'(3'd7), 8'hff, 7'd127, 5'd31, 6'd63, 5'd31, 1'b0, '0},
      '{OP_END,  8'h00, 7'd0, 5'd0, 6'd0, 5'd0, 1'b0, '0},
      '{OP_TEXT, 8'hff, 7'd0, 5'd0, 6'd0, 5'd0, 1'b0, '0},
      '{OP_END,  8'hff, 7'd127, 5'd31, 6'd63, 5'd31, 1'b0, '0}
    };
    foreach (rows[i]) begin
      base = key_queue.size();
      offer_item(rows[i].op, rows[i].b, rows[i].ri, rows[i].pos, rows[i].kid, rows[i].cnt);
      if (rows[i].typed) begin
        while (key_queue.size() > base) key_queue.pop_back();
        key_queue.push_back(rows[i].res);
      end
    end
    drain();

    // A matching text with the key limit at zero still yields only the no-key result.
    write_reg(REG_KEY_LIMIT, 8'd0);
    offer_item(OP_TEXT, 8'h58, '0, '0, '0, '0);
    offer_item(OP_END, '0, '0, '0, '0, '0);
    key_queue.pop_back();
    key_queue.push_back('{6'd0, 1'b0, 1'b1, 7'd0});
    drain();
    // Indexes with no register behind them must be ignored.
    write_reg(2'd2, 8'hff);
    write_reg(2'd3, 8'h00);

    // Random phases over idle modes and register settings.
    for (int ph = 0; ph < 12; ph++) begin
      drain();
      idle_mode = ph % 4;
      write_reg(REG_KEY_LIMIT, (ph < 6) ? mk_pick[ph] : 8'($urandom));
      write_reg(REG_RULE_COUNT, (ph < 6) ? rc_pick[(ph + 2) % 6] : 8'($urandom_range(16)));
      if (ph == 4) begin
        // Long receiver stall while ends of text keep coming, so the block fills.
        hold_left = 400;
        repeat (8) offer_item(OP_END, '0, '0, '0, '0, '0);
      end
      for (int n = 0; n < 2; n++) begin
        case ($urandom_range(9))
          0, 1:    load_rule(($urandom_range(4) == 0) ? $urandom_range(RULES - 1)
                                                      : $urandom_range(7));
          2:       send_noise();
          default: send_text();
        endcase
        if (ph == 7 && n == 0) begin
          // Pause the sender until every result is back.
          push <= 1'b0;
          @(posedge clk);
          while (key_queue.size() != 0) @(posedge clk);
        end
      end
    end

    push <= 1'b0;
    @(posedge clk);
    while (key_queue.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (err_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
